FILE: src/cau_pkg.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Operation codes, default widths and the control records shared by the
// front end, the execution back end and the iterative divide/root unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DataWidthDef    = 32;
  localparam int FractionBitsDef = 16;
  localparam int KindWidth       = 3;
  localparam int QueueDepth      = 4;

  typedef enum logic [KindWidth-1:0] {
    K_ADD  = 3'd0,
    K_SUB  = 3'd1,
    K_MUL  = 3'd2,
    K_DIV  = 3'd3,
    K_CONJ = 3'd4,
    K_MAG  = 3'd5,
    K_EQ   = 3'd6
  } kind_t;

  // Front-end class: long ops use the iterative unit unless divisor is zero.
  typedef struct packed {
    logic long_op;
  } op_class_t;

  typedef struct packed {
    logic start;
    logic is_mag;
    logic ack;
  } iter_req_t;

  typedef struct packed {
    logic idle;
    logic done;
  } iter_sts_t;

endpackage

FILE: src/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply, divide, conjugate, magnitude and compare on
// complex operands in signed fixed point, with saturation.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid/in_ready with kind and operands A and B; one
// result per request leaves on out_valid/out_ready in request order, with
// r_real, r_imag and the is_equal, div_zero and saturated flags.
// A four-entry queue parts the front end from the execution back end.
// Add, subtract, multiply, conjugate and compare pass from the queue through
// the product stage to the output register, one request per cycle sustained
// while out_ready stays high. Divide runs one quotient bit per cycle in an
// iterative unit shared with magnitude, which takes a square root there.
// Later requests wait behind them, keeping order. Divide by zero returns
// zero with div_zero set and bypasses the iterative unit like the short ones.
// A stalled receiver holds the output register; the product stage and queue
// keep filling until the queue is full, then in_ready falls.
// Reset empties the queue and all stages; there is no other state.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int DATA_WIDTH    = DataWidthDef,
  parameter int FRACTION_BITS = FractionBitsDef
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [KindWidth-1:0]         kind,
  input  logic signed [DATA_WIDTH-1:0] a_real,
  input  logic signed [DATA_WIDTH-1:0] a_imag,
  input  logic signed [DATA_WIDTH-1:0] b_real,
  input  logic signed [DATA_WIDTH-1:0] b_imag,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] r_real,
  output logic signed [DATA_WIDTH-1:0] r_imag,
  output logic                         is_equal,
  output logic                         div_zero,
  output logic                         saturated
);

  logic                         q_valid, q_pop;
  kind_t                        q_kind;
  op_class_t                    q_cls;
  logic signed [DATA_WIDTH-1:0] q_ar, q_ai, q_br, q_bi;

  cau_front #(
    .DW (DATA_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .a_real   (a_real),
    .a_imag   (a_imag),
    .b_real   (b_real),
    .b_imag   (b_imag),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_kind   (q_kind),
    .q_cls    (q_cls),
    .q_ar     (q_ar),
    .q_ai     (q_ai),
    .q_br     (q_br),
    .q_bi     (q_bi)
  );

  cau_back #(
    .DW (DATA_WIDTH),
    .FB (FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_kind    (q_kind),
    .q_cls     (q_cls),
    .q_ar      (q_ar),
    .q_ai      (q_ai),
    .q_br      (q_br),
    .q_bi      (q_bi),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .r_real    (r_real),
    .r_imag    (r_imag),
    .is_equal  (is_equal),
    .div_zero  (div_zero),
    .saturated (saturated)
  );

endmodule

FILE: src/cau_front.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Accepts requests, tags each with its class and holds them in a short queue
// for the back end.
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*; #(
  parameter int DW = DataWidthDef
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [KindWidth-1:0] kind,
  input  logic signed [DW-1:0] a_real,
  input  logic signed [DW-1:0] a_imag,
  input  logic signed [DW-1:0] b_real,
  input  logic signed [DW-1:0] b_imag,
  output logic                 q_valid,
  input  logic                 q_pop,
  output kind_t                q_kind,
  output op_class_t            q_cls,
  output logic signed [DW-1:0] q_ar,
  output logic signed [DW-1:0] q_ai,
  output logic signed [DW-1:0] q_br,
  output logic signed [DW-1:0] q_bi
);

  localparam int AW = $clog2(QueueDepth);
  localparam int IW = $bits(op_class_t) + KindWidth + 4 * DW;

  logic [IW-1:0] mem [QueueDepth];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [AW:0]   cnt;
  logic          push;
  op_class_t     cls;
  logic [IW-1:0] head;

  always_comb begin
    cls.long_op = (kind == K_DIV) || (kind == K_MAG);
  end

  assign in_ready = (cnt != (AW + 1)'(QueueDepth));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= {cls, kind, a_real, a_imag, b_real, b_imag};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (q_pop) begin
        rp <= rp + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  assign head   = mem[rp];
  assign q_cls  = op_class_t'(head[IW-1 -: $bits(op_class_t)]);
  assign q_kind = kind_t'(head[4*DW +: KindWidth]);
  assign q_ar   = head[3*DW +: DW];
  assign q_ai   = head[2*DW +: DW];
  assign q_br   = head[DW +: DW];
  assign q_bi   = head[0 +: DW];

endmodule

FILE: src/cau_iter.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit iterative divider and square root
// Two restoring dividers sharing one divisor, one quotient bit per cycle, or
// a bitwise integer square root; it takes a new request only when idle.
// ----------------------------------------------------------------------------
module cau_iter import cau_pkg::*; #(
  parameter int DW = DataWidthDef,
  parameter int FB = FractionBitsDef
) (
  input  logic                 clk,
  input  logic                 rst,
  input  iter_req_t            req,
  input  logic signed [2*DW:0] num_r,
  input  logic signed [2*DW:0] num_i,
  input  logic [2*DW-1:0]      den,
  output iter_sts_t            sts,
  output logic [DW-1:0]        res_r,
  output logic [DW-1:0]        res_i,
  output logic                 sat
);

  localparam int PW = 2 * DW;
  localparam int RW = PW + 1;
  localparam int NW = PW + 1 + FB;
  localparam int CW = $clog2(NW);
  localparam logic [NW:0] LimPos = {{(NW - DW + 2){1'b0}}, {(DW - 1){1'b1}}};
  localparam logic [NW:0] LimNeg = LimPos + 1'b1;
  localparam logic [PW-1:0] MagMax = {{(PW - DW + 1){1'b0}}, {(DW - 1){1'b1}}};

  typedef enum logic [2:0] {
    IT_IDLE = 3'b001,
    IT_RUN  = 3'b010,
    IT_DONE = 3'b100
  } iter_state_t;

  iter_state_t   state;
  logic [CW-1:0] cnt;
  logic          is_mag;
  logic [PW-1:0] dv;
  logic          neg_r, neg_i;
  logic [NW-1:0] dd_r, dd_i, q_r, q_i;
  logic [RW-1:0] rem_r, rem_i;
  logic [PW-1:0] sq_s, sq_r, sq_b;

  logic [RW-1:0] sh_r, sh_i;
  logic          ge_r, ge_i;
  logic [PW-1:0] sq_t;
  logic [PW:0]   mag_r, mag_i;

  function automatic logic [DW:0] fin_div(input logic [NW-1:0] q, input logic [RW-1:0] rem,
                                          input logic [PW-1:0] d, input logic neg);
    logic [NW:0] q1;
    logic [NW:0] lim;
    logic        s;
    q1  = {1'b0, q} + (NW + 1)'({rem, 1'b0} >= {1'b0, d});
    lim = neg ? LimNeg : LimPos;
    s   = 1'b0;
    if (q1 > lim) begin
      q1 = lim;
      s  = 1'b1;
    end
    return {s, neg ? -q1[DW-1:0] : q1[DW-1:0]};
  endfunction

  assign sh_r = {rem_r[RW-2:0], dd_r[NW-1]};
  assign sh_i = {rem_i[RW-2:0], dd_i[NW-1]};
  assign ge_r = sh_r >= {1'b0, dv};
  assign ge_i = sh_i >= {1'b0, dv};
  assign sq_t = sq_r + sq_b;
  assign mag_r = num_r[PW] ? -num_r : num_r;
  assign mag_i = num_i[PW] ? -num_i : num_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IT_IDLE;
    end else begin
      case (state)
        IT_IDLE: if (req.start) state <= IT_RUN;
        IT_RUN:  if (cnt == '0) state <= IT_DONE;
        IT_DONE: if (req.ack) state <= IT_IDLE;
        default: state <= IT_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == IT_IDLE && req.start) begin
      is_mag <= req.is_mag;
      cnt    <= req.is_mag ? CW'(DW - 1) : CW'(NW - 1);
      dv     <= den;
      neg_r  <= num_r[PW];
      neg_i  <= num_i[PW];
      dd_r   <= {mag_r, {FB{1'b0}}};
      dd_i   <= {mag_i, {FB{1'b0}}};
      rem_r  <= '0;
      rem_i  <= '0;
      q_r    <= '0;
      q_i    <= '0;
      sq_s   <= den;
      sq_r   <= '0;
      sq_b   <= PW'(1'b1) << (PW - 2);
    end else if (state == IT_RUN) begin
      cnt <= cnt - 1'b1;
      if (is_mag) begin
        if (sq_s >= sq_t) begin
          sq_s <= sq_s - sq_t;
          sq_r <= (sq_r >> 1) + sq_b;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_b <= sq_b >> 2;
      end else begin
        rem_r <= ge_r ? sh_r - {1'b0, dv} : sh_r;
        rem_i <= ge_i ? sh_i - {1'b0, dv} : sh_i;
        q_r   <= {q_r[NW-2:0], ge_r};
        q_i   <= {q_i[NW-2:0], ge_i};
        dd_r  <= dd_r << 1;
        dd_i  <= dd_i << 1;
      end
    end
  end

  always_comb begin
    logic [DW:0]   fr, fi;
    logic [PW-1:0] m;
    logic          sm;
    fr = fin_div(q_r, rem_r, dv, neg_r);
    fi = fin_div(q_i, rem_i, dv, neg_i);
    m  = sq_r + PW'(sq_s > sq_r);
    sm = m > MagMax;
    if (sm) begin
      m = MagMax;
    end
    if (is_mag) begin
      res_r = m[DW-1:0];
      res_i = '0;
      sat   = sm;
    end else begin
      res_r = fr[DW-1:0];
      res_i = fi[DW-1:0];
      sat   = fr[DW] | fi[DW];
    end
  end

  assign sts.idle = (state == IT_IDLE);
  assign sts.done = (state == IT_DONE);

endmodule

FILE: src/cau_back.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit back end
// Product stage, combinational result and output register; magnitude and
// nonzero divides hold the product stage while the iterative unit works.
// ----------------------------------------------------------------------------
module cau_back import cau_pkg::*; #(
  parameter int DW = DataWidthDef,
  parameter int FB = FractionBitsDef
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  kind_t                q_kind,
  input  op_class_t            q_cls,
  input  logic signed [DW-1:0] q_ar,
  input  logic signed [DW-1:0] q_ai,
  input  logic signed [DW-1:0] q_br,
  input  logic signed [DW-1:0] q_bi,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [DW-1:0] r_real,
  output logic signed [DW-1:0] r_imag,
  output logic                 is_equal,
  output logic                 div_zero,
  output logic                 saturated
);

  localparam int PW = 2 * DW;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] VMax = {{(SW - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
  localparam logic signed [SW-1:0] VMin = {{(SW - DW + 1){1'b1}}, {(DW - 1){1'b0}}};
  localparam logic signed [SW-1:0] Half = {{(SW - FB){1'b0}}, 1'b1, {(FB - 1){1'b0}}};

  logic                 s1_vld;
  kind_t                s1_kind;
  op_class_t            s1_cls;
  logic signed [DW-1:0] s1_ar, s1_ai, s1_br, s1_bi;
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir, sq0, sq1;
  logic                 launched;
  logic                 s1_long, s1_adv, out_free, load;
  logic [PW-1:0]        den;
  logic signed [PW:0]   n_r, n_i;
  iter_req_t            req;
  iter_sts_t            its;
  logic [DW-1:0]        it_r, it_i;
  logic                 it_sat;

  logic signed [DW-1:0] rr, ri;
  logic                 eq, dz, sat;

  function automatic logic [DW:0] clip(input logic signed [SW-1:0] x);
    if (x > VMax) begin
      return {1'b1, VMax[DW-1:0]};
    end else if (x < VMin) begin
      return {1'b1, VMin[DW-1:0]};
    end
    return {1'b0, x[DW-1:0]};
  endfunction

  assign den      = PW'(sq0) + PW'(sq1);
  assign n_r      = (PW + 1)'(p_rr) + (PW + 1)'(p_ii);
  assign n_i      = (PW + 1)'(p_ir) - (PW + 1)'(p_ri);
  assign s1_long  = s1_vld && s1_cls.long_op && ((s1_kind == K_MAG) || (den != '0));
  assign out_free = !out_valid || out_ready;
  assign s1_adv   = s1_vld && out_free && (!s1_long || its.done);
  assign load     = q_valid && (!s1_vld || s1_adv);
  assign q_pop    = load;

  assign req.start  = s1_long && its.idle && !launched;
  assign req.is_mag = (s1_kind == K_MAG);
  assign req.ack    = s1_adv && s1_long;

  always_ff @(posedge clk) begin
    if (load) begin
      s1_kind <= q_kind;
      s1_cls  <= q_cls;
      s1_ar   <= q_ar;
      s1_ai   <= q_ai;
      s1_br   <= q_br;
      s1_bi   <= q_bi;
      p_rr    <= PW'(q_ar) * PW'(q_br);
      p_ii    <= PW'(q_ai) * PW'(q_bi);
      p_ri    <= PW'(q_ar) * PW'(q_bi);
      p_ir    <= PW'(q_ai) * PW'(q_br);
      // The same pair of squarers serves |B|^2 for divide and |A|^2 for magnitude.
      sq0     <= (q_kind == K_MAG) ? PW'(q_ar) * PW'(q_ar) : PW'(q_br) * PW'(q_br);
      sq1     <= (q_kind == K_MAG) ? PW'(q_ai) * PW'(q_ai) : PW'(q_bi) * PW'(q_bi);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld   <= 1'b0;
      launched <= 1'b0;
    end else begin
      if (load) begin
        s1_vld <= 1'b1;
      end else if (s1_adv) begin
        s1_vld <= 1'b0;
      end
      if (s1_adv) begin
        launched <= 1'b0;
      end else if (req.start) begin
        launched <= 1'b1;
      end
    end
  end

  cau_iter #(
    .DW (DW),
    .FB (FB)
  ) u_iter (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .num_r (n_r),
    .num_i (n_i),
    .den   (den),
    .sts   (its),
    .res_r (it_r),
    .res_i (it_i),
    .sat   (it_sat)
  );

  always_comb begin
    logic [DW:0]          c0, c1;
    logic signed [SW-1:0] w0, w1;
    rr  = '0;
    ri  = '0;
    eq  = 1'b0;
    dz  = 1'b0;
    sat = 1'b0;
    c0  = '0;
    c1  = '0;
    w0  = '0;
    w1  = '0;
    case (s1_kind)
      K_ADD, K_SUB: begin
        w0 = (s1_kind == K_ADD) ? SW'(s1_ar) + SW'(s1_br) : SW'(s1_ar) - SW'(s1_br);
        w1 = (s1_kind == K_ADD) ? SW'(s1_ai) + SW'(s1_bi) : SW'(s1_ai) - SW'(s1_bi);
        c0 = clip(w0);
        c1 = clip(w1);
      end
      K_MUL: begin
        // Round to nearest with ties towards plus infinity.
        w0 = (SW'(p_rr) - SW'(p_ii) + Half) >>> FB;
        w1 = (SW'(p_ri) + SW'(p_ir) + Half) >>> FB;
        c0 = clip(w0);
        c1 = clip(w1);
      end
      K_DIV: begin
        if (den == '0) begin
          dz = 1'b1;
        end else begin
          c0 = {it_sat, it_r};
          c1 = {1'b0, it_i};
        end
      end
      K_CONJ: begin
        w1 = -SW'(s1_ai);
        c0 = {1'b0, s1_ar};
        c1 = clip(w1);
      end
      K_MAG: begin
        c0 = {it_sat, it_r};
        c1 = '0;
      end
      K_EQ: begin
        eq = (s1_ar == s1_br) && (s1_ai == s1_bi);
      end
      default: begin
        eq = 1'b0;
      end
    endcase
    rr  = c0[DW-1:0];
    ri  = c1[DW-1:0];
    sat = c0[DW] | c1[DW];
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      r_real    <= rr;
      r_imag    <= ri;
      is_equal  <= eq;
      div_zero  <= dz;
      saturated <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) req.start |-> its.idle)
    else $error("iterative unit started while busy");

  a_launch_held: assert property (@(posedge clk) disable iff (rst) launched |-> s1_vld)
    else $error("launch mark without a request in the product stage");

  a_done_owned: assert property (@(posedge clk) disable iff (rst) its.done |-> launched)
    else $error("iterative result with no waiting request");

endmodule

FILE: bench/complex_arithmetic_unit_tb.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Sends directed and random requests on the input handshake. A local
// fixed-point predictor works out each result, and a checker compares every
// result against the oldest pending prediction. Random gaps and
// back-pressure are applied on both sides.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_tb import cau_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = DataWidthDef;
  localparam int FB = FractionBitsDef;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 2 * DW + FB + 20;
  localparam logic [KindWidth-1:0] KIND_UNUSED = 3'd7;
  localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [DW-1:0] r_real;
    logic signed [DW-1:0] r_imag;
    logic                 is_equal;
    logic                 div_zero;
    logic                 saturated;
  } cplx_result_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [KindWidth-1:0] kind;
  logic signed [DW-1:0] a_real, a_imag, b_real, b_imag;
  logic out_valid;
  logic out_ready;
  logic signed [DW-1:0] r_real, r_imag;
  logic is_equal, div_zero, saturated;

  cplx_result_t pending_results[$];
  int  error_count = 0;
  int  cycle_count = 0;
  bit  steady = 1'b0;  // when set, neither side idles
  int  ready_hold = 0;

  complex_arithmetic_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .a_real(a_real), .a_imag(a_imag), .b_real(b_real), .b_imag(b_imag),
    .out_valid(out_valid), .out_ready(out_ready),
    .r_real(r_real), .r_imag(r_imag),
    .is_equal(is_equal), .div_zero(div_zero), .saturated(saturated)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 19);
    if (roll < 12) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------- predictor
  function automatic logic signed [DW-1:0] clip_part(input wide_t x, inout bit sat);
    if (x > wide_t'(VMAX)) begin
      sat = 1'b1;
      return VMAX;
    end
    if (x < wide_t'(VMIN)) begin
      sat = 1'b1;
      return VMIN;
    end
    return x[DW-1:0];
  endfunction

  // Rounds num * 2^FB / den to nearest, halves away from zero.
  function automatic logic signed [DW-1:0] div_part(input wide_t num, input wide_t den,
                                                   inout bit sat);
    bit    neg;
    wide_t mag, quo, rem, lim;
    neg = num < 0;
    mag = (neg ? -num : num) <<< FB;
    quo = mag / den;
    rem = mag % den;
    if (rem >= den - rem) quo = quo + 1;
    lim = neg ? (wide_t'(1) <<< (DW - 1)) : (wide_t'(1) <<< (DW - 1)) - 1;
    if (quo > lim) begin
      sat = 1'b1;
      quo = lim;
    end
    return neg ? -quo[DW-1:0] : quo[DW-1:0];
  endfunction

  // Integer square root rounded to nearest.
  function automatic longint unsigned root_round(input longint unsigned s);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s = s - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    if (s > root) root++;
    return root;
  endfunction

  function automatic cplx_result_t predict_result(input logic [KindWidth-1:0] op,
                                                  input logic signed [DW-1:0] xr, xi, yr, yi);
    cplx_result_t    res;
    wide_t           ar, ai, br, bi, den, half;
    longint unsigned mag;
    bit              sat;
    ar = xr; ai = xi; br = yr; bi = yi;
    half = wide_t'(1) <<< (FB - 1);
    sat = 1'b0;
    res = '{default: '0};
    case (op)
      K_ADD: begin
        res.r_real = clip_part(ar + br, sat);
        res.r_imag = clip_part(ai + bi, sat);
      end
      K_SUB: begin
        res.r_real = clip_part(ar - br, sat);
        res.r_imag = clip_part(ai - bi, sat);
      end
      K_MUL: begin
        res.r_real = clip_part((ar * br - ai * bi + half) >>> FB, sat);
        res.r_imag = clip_part((ar * bi + ai * br + half) >>> FB, sat);
      end
      K_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          res.div_zero = 1'b1;
        end else begin
          res.r_real = div_part(ar * br + ai * bi, den, sat);
          res.r_imag = div_part(ai * br - ar * bi, den, sat);
        end
      end
      K_CONJ: begin
        res.r_real = xr;
        res.r_imag = clip_part(-ai, sat);
      end
      K_MAG: begin
        mag = root_round(64'(ar * ar + ai * ai));
        if (mag > 64'(VMAX)) begin
          sat = 1'b1;
          mag = 64'(VMAX);
        end
        res.r_real = mag[DW-1:0];
      end
      K_EQ: res.is_equal = (xr == yr) && (xi == yi);
      default: ;
    endcase
    res.saturated = sat;
    return res;
  endfunction

  // ---------------------------------------------------------------- driving
  task automatic send_request(input logic [KindWidth-1:0] op,
                              input logic signed [DW-1:0] xr, xi, yr, yi);
    int gap;
    in_valid <= 1'b1;
    kind     <= op;
    a_real   <= xr;
    a_imag   <= xi;
    b_real   <= yr;
    b_imag   <= yi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_result(op, xr, xi, yr, yi));
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      ready_hold = 0;
    end else if (ready_hold > 0) begin
      ready_hold--;
      out_ready <= 1'b0;
    end else if (!steady && $urandom_range(0, 9) < 2) begin
      ready_hold = pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- checking
  always @(posedge clk) begin
    cplx_result_t exp_res;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (r_real !== exp_res.r_real) begin
          $error("r_real expected %h actual %h", exp_res.r_real, r_real);
          error_count++;
        end
        if (r_imag !== exp_res.r_imag) begin
          $error("r_imag expected %h actual %h", exp_res.r_imag, r_imag);
          error_count++;
        end
        if (is_equal !== exp_res.is_equal) begin
          $error("is_equal expected %b actual %b", exp_res.is_equal, is_equal);
          error_count++;
        end
        if (div_zero !== exp_res.div_zero) begin
          $error("div_zero expected %b actual %b", exp_res.div_zero, div_zero);
          error_count++;
        end
        if (saturated !== exp_res.saturated) begin
          $error("saturated expected %b actual %b", exp_res.saturated, saturated);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests
  function automatic logic signed [DW-1:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return VMAX;
      1: return VMIN;
      2: return '0;
      3: return DW'(signed'($urandom_range(0, 1 << 21)) - (1 << 20));
      4: return DW'(signed'($urandom_range(0, 1 << 25)) - (1 << 24));
      default: return DW'($urandom);
    endcase
  endfunction

  task automatic test_add_sub();
    send_request(K_ADD, VMAX, VMIN, 32'sd1, -32'sd1);
    send_request(K_ADD, 32'sh0001_8000, -32'sh0002_0000, 32'sh0000_8000, 32'sh0001_0000);
    send_request(K_SUB, VMIN, VMAX, 32'sd1, -32'sd1);
    send_request(K_SUB, VMAX, VMIN, VMAX, VMIN);
  endtask

  task automatic test_multiply();
    send_request(K_MUL, VMAX, VMAX, VMAX, VMAX);
    send_request(K_MUL, VMIN, VMIN, VMIN, VMIN);
    send_request(K_MUL, 32'sh0002_0000, 32'sh0000_8000, 32'sh0001_8000, -32'sh0003_0000);
    // Exact halves exercise round-to-nearest with ties upward.
    send_request(K_MUL, 32'sd1, 32'sd0, 32'sh0000_8000, 32'sd0);
    send_request(K_MUL, -32'sd1, 32'sd0, 32'sh0000_8000, 32'sd0);
  endtask

  task automatic test_divide();
    send_request(K_DIV, 32'sh0001_0000, 32'sh0002_0000, 32'sd0, 32'sd0);
    send_request(K_DIV, VMAX, VMIN, 32'sd1, 32'sd0);
    send_request(K_DIV, 32'sh0003_0000, -32'sh0001_0000, 32'sh0001_0000, 32'sh0002_0000);
    send_request(K_DIV, VMIN, VMIN, VMIN, VMIN);
    send_request(K_DIV, 32'sd1, 32'sd0, 32'sh0002_0000, 32'sd0);
  endtask

  task automatic test_unary();
    send_request(K_CONJ, VMAX, VMIN, 32'sd5, 32'sd7);
    send_request(K_CONJ, VMIN, VMAX, 32'sd0, 32'sd0);
    send_request(K_MAG, VMIN, VMIN, 32'sd0, 32'sd0);
    send_request(K_MAG, 32'sh0003_0000, -32'sh0004_0000, 32'sd0, 32'sd0);
    send_request(K_MAG, 32'sd0, 32'sd0, VMAX, VMAX);
  endtask

  task automatic test_compare_and_unused();
    send_request(K_EQ, VMIN, VMAX, VMIN, VMAX);
    send_request(K_EQ, VMIN, VMAX, VMIN, VMAX - 1);
    send_request(K_EQ, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_request(KIND_UNUSED, VMAX, VMIN, VMAX, VMIN);
  endtask

  task automatic test_random(input int count);
    logic [KindWidth-1:0]  op;
    logic signed [DW-1:0]  xr, xi, yr, yi;
    for (int n = 0; n < count; n++) begin
      // Alternate stretches with and without idling.
      if (n % 100 == 0) steady = ($urandom_range(0, 3) == 0);
      op = KindWidth'($urandom_range(0, 7));
      xr = rand_operand();
      xi = rand_operand();
      yr = rand_operand();
      yi = rand_operand();
      if (op == K_EQ && $urandom_range(0, 1)) begin
        yr = xr;
        if ($urandom_range(0, 2) != 0) yi = xi;
      end
      send_request(op, xr, xi, yr, yi);
    end
    steady = 1'b0;
  endtask

  initial begin
    rst      <= 1'b1;
    in_valid <= 1'b0;
    kind     <= '0;
    a_real   <= '0;
    a_imag   <= '0;
    b_real   <= '0;
    b_imag   <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_add_sub();
    test_multiply();
    test_divide();
    test_unary();
    test_compare_and_unused();
    test_random(580);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/cau_pkg.sv
src/cau_front.sv
src/cau_iter.sv
src/cau_back.sv
src/complex_arithmetic_unit.sv
bench/complex_arithmetic_unit_tb.sv
